// ===== rtl/core/windmill_streak_artifact_eval_macros.svh =====
// Assertion macros used by the checker file wse_check.sv.
`ifndef WINDMILL_STREAK_ARTIFACT_EVAL_MACROS_SVH
`define WINDMILL_STREAK_ARTIFACT_EVAL_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define WSE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("windmill streak assertion failed");

// Clocked assertion that also holds during reset.
`define WSE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("windmill streak assertion failed");

`endif

// ===== rtl/core/wse_pkg.sv =====
`default_nettype none
package wse_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int COORD_BITS    = 24;
    localparam int TABLE_LEN     = 24;
    localparam int MOD_STEPS     = 22;

    localparam int DX_W  = COORD_BITS + 1;
    localparam int VEC_W = COORD_BITS + 12;
    localparam int D_W   = VEC_W - 1;
    localparam int ANG_W = 34;
    localparam int ROT_W = 34;
    localparam int MOD_W = 56;

    localparam int PIPE_LEN = 2 * CORDIC_STAGES + 8 + MOD_STEPS;
    localparam int LATENCY  = PIPE_LEN + 2;

    localparam logic signed [ANG_W-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] START_Q30    = 34'sd2529944570;
    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [15:0]             INV_GAIN_Q16 = 16'd39797;
    localparam logic [22:0]             OUT_MAX      = 23'h7FFFFF;

    localparam logic [2:0] CFG_GAIN    = 3'd0;
    localparam logic [2:0] CFG_FREQ    = 3'd1;
    localparam logic [2:0] CFG_TWIST   = 3'd2;
    localparam logic [2:0] CFG_INV_LEN = 3'd3;
    localparam logic [2:0] CFG_INV_SS  = 3'd4;

    typedef struct packed {
        logic [15:0] gain;
        logic [23:0] freq;
        logic [15:0] twist;
        logic [23:0] inv_len;
        logic [19:0] inv_ss;
    } t_cfg;

    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic signed [23:0]     pz;
        logic signed [23:0]     peak;
        logic                   zero;
    } t_item;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wse_front.sv =====
`default_nettype none
module wse_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic signed [23:0]   i_pos_x,
    input  wire logic signed [23:0]   i_pos_y,
    input  wire logic signed [23:0]   i_pos_z,
    input  wire logic signed [23:0]   i_near_x,
    input  wire logic signed [23:0]   i_near_y,
    input  wire logic                 i_near_found,
    input  wire logic                 i_occupied,
    input  wire logic signed [23:0]   i_structure_density,
    input  wire logic signed [23:0]   i_peak_density,
    input  wire wse_pkg::t_cfg        i_cfg,
    output logic                      o_vld,
    output wse_pkg::t_item            o_item
);

    localparam logic signed [33:0] LIM_HI = (34'sd1 <<< wse_pkg::COORD_BITS) - 34'sd1;
    localparam logic signed [33:0] LIM_LO = -(34'sd1 <<< wse_pkg::COORD_BITS);

    logic signed [24:0] diff_x, diff_y;
    logic signed [33:0] ext_x, ext_y, sat_x, sat_y;
    logic               zero;
    logic               r_vld;
    wse_pkg::t_item     r_item;

    assign diff_x = 25'(i_near_x) - 25'(i_pos_x);
    assign diff_y = 25'(i_near_y) - 25'(i_pos_y);
    assign ext_x  = 34'(diff_x);
    assign ext_y  = 34'(diff_y);

    always_comb begin
        sat_x = (ext_x > LIM_HI) ? LIM_HI : ((ext_x < LIM_LO) ? LIM_LO : ext_x);
        sat_y = (ext_y > LIM_HI) ? LIM_HI : ((ext_y < LIM_LO) ? LIM_LO : ext_y);
        zero  = i_occupied || !i_near_found || i_peak_density[23]
             || i_structure_density[23] || (i_structure_density == 24'sd0)
             || ((diff_x == 25'sd0) && (diff_y == 25'sd0))
             || (i_cfg.freq == 24'd0) || (i_cfg.inv_len == 24'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item.dx   <= sat_x[wse_pkg::DX_W-1:0];
            r_item.dy   <= sat_y[wse_pkg::DX_W-1:0];
            r_item.pz   <= i_pos_z;
            r_item.peak <= i_peak_density;
            r_item.zero <= zero;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule
`default_nettype wire

// ===== rtl/core/wse_queue.sv =====
`default_nettype none
module wse_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire wse_pkg::t_item  i_item,
    output logic                 o_vld,
    output logic                 o_full,
    output wse_pkg::t_item       o_item
);

    wse_pkg::t_item r_mem [0:1];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;
    logic           pop;

    assign pop    = (r_cnt != 2'd0);
    assign o_vld  = pop;
    assign o_full = (r_cnt == 2'd2);
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/wse_back.sv =====
`default_nettype none
module wse_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire wse_pkg::t_item  i_item,
    input  wire wse_pkg::t_cfg   i_cfg,
    output logic                 o_vld,
    output logic [22:0]          o_density
);

    localparam int N     = wse_pkg::CORDIC_STAGES;
    localparam int R     = wse_pkg::MOD_STEPS;
    localparam int L     = wse_pkg::PIPE_LEN;
    localparam int VEC_W = wse_pkg::VEC_W;
    localparam int D_W   = wse_pkg::D_W;
    localparam int ANG_W = wse_pkg::ANG_W;
    localparam int ROT_W = wse_pkg::ROT_W;
    localparam int MOD_W = wse_pkg::MOD_W;
    localparam logic [MOD_W-1:0] MOD_PI   = MOD_W'(wse_pkg::PI_Q30);
    localparam logic [MOD_W-1:0] MOD_HALF = MOD_W'(wse_pkg::HALF_PI_Q30);

    logic                    r_vld  [1:L];
    logic                    r_zero [1:L-1];
    logic signed [23:0]      r_pk   [1:N+4];

    logic signed [VEC_W-1:0] r_vx [0:N];
    logic signed [VEC_W-1:0] r_vy [0:N];
    logic signed [ANG_W-1:0] r_vz [0:N];
    logic signed [44:0]      r_m1;
    logic signed [61:0]      r_m2;
    logic signed [MOD_W-1:0] r_sf [0:N-1];

    logic [D_W-1:0]          r_d;
    logic signed [57:0]      r_p;
    logic signed [MOD_W-1:0] r_q;
    logic [D_W+23:0]         r_prod;
    logic                    r_dfar;
    logic [MOD_W-1:0]        r_r [0:R];
    logic [24:0]             r_distf;

    logic signed [ROT_W-1:0] r_rx [0:N];
    logic signed [ROT_W-1:0] r_ry [0:N];
    logic signed [ANG_W-1:0] r_rz [0:N];
    logic [24:0]             r_cosq;
    logic [27:0]             r_a [0:N+1+R];
    logic [28:0]             r_b;
    logic [22:0]             r_c;

    logic signed [VEC_W-1:0] px0, py0;
    logic [VEC_W+14:0]       dprod;
    logic [40:0]             rem;
    logic                    pfar;
    logic signed [2*ROT_W-1:0] sq;
    logic [47:0]             amul;
    logic [52:0]             bmul;
    logic [44:0]             cmul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[1] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[1] <= i_item.zero;
        r_pk[1]   <= i_item.peak;
    end

    for (genvar k = 2; k <= L; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    for (genvar k = 2; k <= L - 1; k++) begin : g_zero
        always_ff @(posedge i_clk) begin
            r_zero[k] <= r_zero[k-1];
        end
    end

    for (genvar k = 2; k <= N + 4; k++) begin : g_pk
        always_ff @(posedge i_clk) begin
            r_pk[k] <= r_pk[k-1];
        end
    end

    assign px0 = VEC_W'(i_item.dx) <<< 8;
    assign py0 = VEC_W'(i_item.dy) <<< 8;

    always_ff @(posedge i_clk) begin
        if (px0 < 0) begin
            r_vx[0] <= -px0;
            r_vy[0] <= -py0;
            r_vz[0] <= (py0 >= 0) ? wse_pkg::PI_Q30 : -wse_pkg::PI_Q30;
        end else begin
            r_vx[0] <= px0;
            r_vy[0] <= py0;
            r_vz[0] <= '0;
        end
        r_m1    <= 45'(i_item.pz) * $signed({1'b0, i_cfg.inv_ss});
        r_m2    <= 62'(r_m1) * $signed({1'b0, i_cfg.twist});
        r_sf[0] <= MOD_W'(r_m2 >>> 7);
    end

    for (genvar k = 1; k < N; k++) begin : g_sf
        always_ff @(posedge i_clk) begin
            r_sf[k] <= r_sf[k-1];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (r_vy[g] >= 0) begin
                r_vx[g+1] <= r_vx[g] + (r_vy[g] >>> g);
                r_vy[g+1] <= r_vy[g] - (r_vx[g] >>> g);
                r_vz[g+1] <= r_vz[g] + wse_pkg::atan_q30(5'(g));
            end else begin
                r_vx[g+1] <= r_vx[g] - (r_vy[g] >>> g);
                r_vy[g+1] <= r_vy[g] + (r_vx[g] >>> g);
                r_vz[g+1] <= r_vz[g] - wse_pkg::atan_q30(5'(g));
            end
        end
    end

    assign dprod = (VEC_W+15)'(r_vx[N][VEC_W-2:0]) * (VEC_W+15)'(wse_pkg::INV_GAIN_Q16);
    assign rem   = (41'd1 << 40) - r_prod[40:0];
    assign pfar  = (64'(r_prod) >= (64'd1 << 40));

    always_ff @(posedge i_clk) begin
        r_d    <= dprod[VEC_W+14:16];
        r_p    <= 58'(r_vz[N]) * $signed({1'b0, i_cfg.freq});
        r_q    <= MOD_W'(r_p >>> 16) + r_sf[N-1] + MOD_W'(wse_pkg::START_Q30);
        r_prod <= (D_W+24)'(r_d) * (D_W+24)'(i_cfg.inv_len);
        r_dfar <= (64'(r_d) >= (64'd1 << 40));
        r_r[0] <= (r_q < 0) ? (MOD_W'(r_q) + (MOD_PI << (R - 1))) : MOD_W'(r_q);
        r_distf <= (r_dfar || pfar) ? 25'd0 : rem[40:16];
    end

    for (genvar j = 0; j < R; j++) begin : g_mod
        always_ff @(posedge i_clk) begin
            if (r_r[j] >= (MOD_PI << (R - 1 - j))) begin
                r_r[j+1] <= r_r[j] - (MOD_PI << (R - 1 - j));
            end else begin
                r_r[j+1] <= r_r[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx[0] <= wse_pkg::INV_GAIN_Q30;
        r_ry[0] <= '0;
        if (r_r[R] > MOD_HALF) begin
            r_rz[0] <= ANG_W'(r_r[R]) - wse_pkg::PI_Q30;
        end else begin
            r_rz[0] <= ANG_W'(r_r[R]);
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (r_rz[g] >= 0) begin
                r_rx[g+1] <= r_rx[g] - (r_ry[g] >>> g);
                r_ry[g+1] <= r_ry[g] + (r_rx[g] >>> g);
                r_rz[g+1] <= r_rz[g] - wse_pkg::atan_q30(5'(g));
            end else begin
                r_rx[g+1] <= r_rx[g] + (r_ry[g] >>> g);
                r_ry[g+1] <= r_ry[g] - (r_rx[g] >>> g);
                r_rz[g+1] <= r_rz[g] + wse_pkg::atan_q30(5'(g));
            end
        end
    end

    assign sq   = (2*ROT_W)'(r_rx[N]) * (2*ROT_W)'(r_rx[N]);
    assign amul = 48'(r_pk[N+4][22:0]) * 48'(r_distf);
    assign bmul = 53'(r_a[N+1+R]) * 53'(r_cosq);
    assign cmul = 45'(r_b) * 45'(i_cfg.gain);

    always_ff @(posedge i_clk) begin
        r_a[0] <= amul[47:20];
        if (sq[2*ROT_W-1:36] > (2*ROT_W-36)'(25'h1000000)) begin
            r_cosq <= 25'h1000000;
        end else begin
            r_cosq <= sq[60:36];
        end
        r_b <= bmul[52:24];
        if (r_zero[L-1]) begin
            r_c <= '0;
        end else if (cmul[44:16] > 29'(wse_pkg::OUT_MAX)) begin
            r_c <= wse_pkg::OUT_MAX;
        end else begin
            r_c <= cmul[38:16];
        end
    end

    for (genvar k = 1; k <= N + 1 + R; k++) begin : g_a
        always_ff @(posedge i_clk) begin
            r_a[k] <= r_a[k-1];
        end
    end

    assign o_vld     = r_vld[L];
    assign o_density = r_c;

endmodule
`default_nettype wire

// ===== rtl/core/windmill_streak_artifact_eval.sv =====
// Windmill streak artifact evaluator.
// Input channel: raise start with one voxel on the i_ ports; the transaction
// is taken at a rising edge where start is high and busy is low.
// Output channel: o_valid marks o_artifact_density for exactly one cycle;
// the receiver cannot stall, so results are never held back.
// Configuration: write i_cfg_wdata to register i_cfg_idx while i_cfg_we is
// high (0 gain, 1 spoke frequency, 2 twist, 3 inverse length, 4 inverse
// slice spacing); unknown indexes are dropped. Write only while idle.
// Throughput: one voxel per cycle, sustained; busy stays low in operation.
// The path from accept to strobe is set by the vectoring CORDIC, the 22-step
// modulo-pi reduction of the phase and the rotation CORDIC, each one pipeline
// register a step.
// The front registers and classifies each voxel, a two-entry queue hands it
// to the back pipeline, which drains it every cycle.
// Reset (synchronous, active low) clears all valid flags and the queue, and
// loads the register defaults: gain 0.0625, inverse slice spacing 1.0, others 0.
`default_nettype none
module windmill_streak_artifact_eval (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [23:0]   i_pos_x,
    input  wire logic signed [23:0]   i_pos_y,
    input  wire logic signed [23:0]   i_pos_z,
    input  wire logic signed [23:0]   i_near_x,
    input  wire logic signed [23:0]   i_near_y,
    input  wire logic                 i_near_found,
    input  wire logic                 i_occupied,
    input  wire logic signed [23:0]   i_structure_density,
    input  wire logic signed [23:0]   i_peak_density,
    output logic                      o_valid,
    output logic [22:0]               o_artifact_density,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [23:0]          i_cfg_wdata
);

    wse_pkg::t_cfg  r_cfg;
    wse_pkg::t_item front_item, queue_item;
    logic           accept, front_vld, queue_vld, queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain    <= 16'd4096;
            r_cfg.freq    <= '0;
            r_cfg.twist   <= '0;
            r_cfg.inv_len <= '0;
            r_cfg.inv_ss  <= 20'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wse_pkg::CFG_GAIN:    r_cfg.gain    <= i_cfg_wdata[15:0];
                wse_pkg::CFG_FREQ:    r_cfg.freq    <= i_cfg_wdata;
                wse_pkg::CFG_TWIST:   r_cfg.twist   <= i_cfg_wdata[15:0];
                wse_pkg::CFG_INV_LEN: r_cfg.inv_len <= i_cfg_wdata;
                wse_pkg::CFG_INV_SS:  r_cfg.inv_ss  <= i_cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    assign busy   = queue_full;
    assign accept = start && !queue_full;

    wse_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_pos_z             (i_pos_z),
        .i_near_x            (i_near_x),
        .i_near_y            (i_near_y),
        .i_near_found        (i_near_found),
        .i_occupied          (i_occupied),
        .i_structure_density (i_structure_density),
        .i_peak_density      (i_peak_density),
        .i_cfg               (r_cfg),
        .o_vld               (front_vld),
        .o_item              (front_item)
    );

    wse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_item  (front_item),
        .o_vld   (queue_vld),
        .o_full  (queue_full),
        .o_item  (queue_item)
    );

    wse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (queue_vld),
        .i_item    (queue_item),
        .i_cfg     (r_cfg),
        .o_vld     (o_valid),
        .o_density (o_artifact_density)
    );

endmodule
`default_nettype wire

// ===== rtl/core/wse_check.sv =====
`default_nettype none
`include "windmill_streak_artifact_eval_macros.svh"
module wse_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_near_found,
    input wire logic        i_occupied,
    input wire logic        o_valid,
    input wire logic [22:0] o_artifact_density
);

    localparam int LAT = wse_pkg::LATENCY;

    wire logic early_zero;

    assign early_zero = start && !busy && (i_occupied || !i_near_found);

    `WSE_ASSERT(a_never_busy, i_clk, i_rst_n, !busy)
    `WSE_ASSERT(a_result_follows, i_clk, i_rst_n, (start && !busy) |-> ##LAT o_valid)
    `WSE_ASSERT(a_no_spurious, i_clk, i_rst_n, o_valid |-> $past(start && !busy, LAT))
    `WSE_ASSERT(a_early_zero, i_clk, i_rst_n, early_zero |-> ##LAT (o_artifact_density == 23'd0))
    `WSE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind windmill_streak_artifact_eval wse_check u_wse_check (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_near_found       (i_near_found),
    .i_occupied         (i_occupied),
    .o_valid            (o_valid),
    .o_artifact_density (o_artifact_density)
);
`default_nettype wire

// ===== test/tb_windmill_streak_artifact_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_windmill_streak_artifact_eval;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         RUN_LIMIT  = 400000;

    typedef struct {
        logic signed [23:0] pos_x, pos_y, pos_z, near_x, near_y;
        logic               near_found, occupied;
        logic signed [23:0] structure_density, peak_density;
    } t_voxel;

    typedef struct {
        t_voxel      vox;
        bit          known;
        logic [22:0] density;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic signed [23:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0, i_near_x = 0, i_near_y = 0;
    logic        i_near_found = 0, i_occupied = 0;
    logic signed [23:0] i_structure_density = 0, i_peak_density = 0;
    logic        o_valid;
    logic [22:0] o_artifact_density;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [23:0] i_cfg_wdata = 0;

    windmill_streak_artifact_eval dut (.*);

    always #10 i_clk = ~i_clk;

    longint      gain, freq, twist, inv_len, inv_ss;
    logic [22:0] density_q[$];
    int          fails = 0;
    int          cycles = 0;

    const longint atan_tab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767};

    function automatic longint mod_floor(longint v, longint m);
        longint r;
        r = v % m;
        return (r < 0) ? r + m : r;
    endfunction

    function automatic logic [22:0] artifact_of(t_voxel v);
        longint pi_q, lim, dx, dy, x, y, z, xs, ys, d, distf, t, ph, cosq, a, b, c;
        longint unsigned prod;
        pi_q = longint'(wse_pkg::PI_Q30);
        lim = longint'(1) << 24;
        if (v.occupied || !v.near_found || v.peak_density < 0 || v.structure_density <= 0)
            return '0;
        dx = longint'(v.near_x) - longint'(v.pos_x);
        dy = longint'(v.near_y) - longint'(v.pos_y);
        if (dx == 0 && dy == 0) return '0;
        if (freq == 0 || inv_len == 0) return '0;
        dx = ((dx < -lim) ? -lim : (dx > lim - 1) ? lim - 1 : dx) * 256;
        dy = ((dy < -lim) ? -lim : (dy > lim - 1) ? lim - 1 : dy) * 256;
        x = dx; y = dy; z = 0;
        if (x < 0) begin
            z = (dy >= 0) ? pi_q : -pi_q;
            x = -x; y = -y;
        end
        for (int i = 0; i < wse_pkg::CORDIC_STAGES; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_tab[i];
            end else begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        d = (x * longint'(wse_pkg::INV_GAIN_Q16)) >>> 16;
        if (d >= (longint'(1) << 40)) begin
            distf = 0;
        end else begin
            prod = longint'(unsigned'(d)) * inv_len;
            distf = (prod >= (64'd1 << 40)) ? 0 : longint'(((64'd1 << 40) - prod) >> 16);
        end
        t = mod_floor(z * freq, pi_q << 16) >> 16;
        ph = mod_floor(longint'(v.pos_z) * inv_ss * twist, pi_q << 7) >> 7;
        ph = (t + ph + longint'(wse_pkg::START_Q30)) % pi_q;
        if (ph > longint'(wse_pkg::HALF_PI_Q30)) ph -= pi_q;
        x = longint'(wse_pkg::INV_GAIN_Q30); y = 0; z = ph;
        for (int i = 0; i < wse_pkg::CORDIC_STAGES; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        cosq = (x * x) >>> 36;
        if (cosq > (longint'(1) << 24)) cosq = longint'(1) << 24;
        a = (longint'(v.peak_density) * distf) >>> 20;
        b = (a * cosq) >>> 24;
        c = (b * gain) >>> 16;
        if (c > longint'(wse_pkg::OUT_MAX)) c = longint'(wse_pkg::OUT_MAX);
        return c[22:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, longint val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_wdata <= val[23:0];
        @(posedge i_clk);
        case (idx)
            wse_pkg::CFG_GAIN:    gain    = val & 64'hFFFF;
            wse_pkg::CFG_FREQ:    freq    = val & 64'hFFFFFF;
            wse_pkg::CFG_TWIST:   twist   = val & 64'hFFFF;
            wse_pkg::CFG_INV_LEN: inv_len = val & 64'hFFFFFF;
            wse_pkg::CFG_INV_SS:  inv_ss  = val & 64'hFFFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(longint g, longint f, longint tw, longint il, longint ss);
        write_reg(wse_pkg::CFG_GAIN, g);
        write_reg(wse_pkg::CFG_FREQ, f);
        write_reg(wse_pkg::CFG_TWIST, tw);
        write_reg(wse_pkg::CFG_INV_LEN, il);
        write_reg(wse_pkg::CFG_INV_SS, ss);
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        wait (density_q.size() == 0);
        repeat (wse_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send(t_voxel v, bit known, logic [22:0] typed, int gap);
        logic [22:0] e;
        start <= 1;
        i_pos_x <= v.pos_x; i_pos_y <= v.pos_y; i_pos_z <= v.pos_z;
        i_near_x <= v.near_x; i_near_y <= v.near_y;
        i_near_found <= v.near_found; i_occupied <= v.occupied;
        i_structure_density <= v.structure_density; i_peak_density <= v.peak_density;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        e = artifact_of(v);
        if (known && e !== typed) begin
            $error("artifact_density predictor expected %0d actual %0d", typed, e);
            fails++;
        end
        density_q.push_back(known ? typed : e);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_voxel random_voxel();
        t_voxel v;
        int     spread;
        v.pos_x = 24'($urandom); v.pos_y = 24'($urandom); v.pos_z = 24'($urandom);
        v.near_x = 24'($urandom); v.near_y = 24'($urandom);
        v.structure_density = 24'($urandom); v.peak_density = 24'($urandom);
        v.near_found = 1'($urandom); v.occupied = 1'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            v.near_found = 1; v.occupied = 0;
            v.structure_density = 24'($urandom_range(1, 8388607));
            v.peak_density = 24'($urandom_range(0, 8388607));
            if ($urandom_range(0, 2) != 0) begin
                spread = 1 << $urandom_range(0, 20);
                v.pos_x = 24'($signed($urandom_range(0, 8388607)) - 4194304);
                v.pos_y = 24'($signed($urandom_range(0, 8388607)) - 4194304);
                v.near_x = 24'(v.pos_x + $signed($urandom_range(0, 2 * spread)) - spread);
                v.near_y = 24'(v.pos_y + $signed($urandom_range(0, 2 * spread)) - spread);
                if ($urandom_range(0, 3) == 0)
                    v.pos_z = 24'($signed($urandom_range(0, 8191)) - 4096);
            end
        end
        return v;
    endfunction

    t_row rows[$];

    function automatic t_voxel vox(int px, int py, int pz, int nx, int ny, bit f, bit o,
                                   int sd, int pk);
        t_voxel v;
        v.pos_x = 24'(px); v.pos_y = 24'(py); v.pos_z = 24'(pz);
        v.near_x = 24'(nx); v.near_y = 24'(ny);
        v.near_found = f; v.occupied = o;
        v.structure_density = 24'(sd); v.peak_density = 24'(pk);
        return v;
    endfunction

    initial begin
        rows = '{
            '{vox(0, 0, 0, 256, 0, 1, 1, 256, 1000), 1, 0},
            '{vox(0, 0, 0, 256, 0, 0, 0, 256, 1000), 1, 0},
            '{vox(0, 0, 0, 256, 0, 1, 0, 256, -1), 1, 0},
            '{vox(0, 0, 0, 256, 0, 1, 0, 0, 1000), 1, 0},
            '{vox(0, 0, 0, 256, 0, 1, 0, -8388608, 1000), 1, 0},
            '{vox(500, -700, 9, 500, -700, 1, 0, 256, 1000), 1, 0},
            '{vox(0, 0, 0, 256, 0, 1, 0, 256, 0), 1, 0},
            '{vox(-8388608, -8388608, -8388608, 8388607, 8388607, 1, 0, 8388607, 8388607), 0, 0},
            '{vox(8388607, 8388607, 8388607, -8388608, -8388608, 1, 0, 1, 8388607), 0, 0},
            '{vox(0, 0, 8388607, 1, 0, 1, 0, 100, 8388607), 0, 0},
            '{vox(0, 0, -8388608, 0, 1, 1, 0, 100, 8388607), 0, 0},
            '{vox(0, 0, 0, 256, 0, 1, 0, 256, 8388607), 0, 0},
            '{vox(0, 0, 0, -256, 0, 1, 0, 256, 8388607), 0, 0},
            '{vox(0, 0, 0, -256, -256, 1, 0, 256, 8388607), 0, 0},
            '{vox(0, 0, 0, 0, 256, 1, 0, 256, 8388607), 0, 0},
            '{vox(0, 0, 0, 0, -256, 1, 0, 256, 8388607), 0, 0},
            '{vox(0, 0, 0, 256, 256, 1, 0, 256, 8388607), 0, 0},
            '{vox(100, 200, 300, -4000, 9000, 1, 0, 5000, 12345), 0, 0}
        };
        gain = 4096; freq = 0; twist = 0; inv_len = 0; inv_ss = 65536;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (rows[k]) send(rows[k].vox, rows[k].known, rows[k].density, k % 3);
        start <= 0;
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(40960, 65536, 51472, 1, 1048575);
                1: write_all(0, 16777215, 0, 16777215, 0);
                2: write_all(4096, 1, 8192, 1 << 12, 65536);
                7: write_all(40960, 16777215, 51472, 16777215, 1048575);
                default: write_all($urandom_range(0, 40960), $urandom_range(1, 16777215),
                                   $urandom_range(0, 51472), 1 << $urandom_range(0, 23),
                                   $urandom_range(0, 1048575));
            endcase
            if (ph == 0)
                foreach (rows[k]) send(rows[k].vox, rows[k].known, rows[k].density, 0);
            for (int n = 0; n < 130; n++) begin
                if (n == 60) begin
                    start <= 0;
                    wait (density_q.size() == 0);
                    @(posedge i_clk);
                end
                send(random_voxel(), 0, 0, ((n / 20) % 2 == 0) ? 0 : $urandom_range(0, 18));
            end
            start <= 0;
            drain();
        end
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (density_q.size() == 0) begin
                $error("artifact_density unexpected result %0d", o_artifact_density);
                fails++;
            end else if (o_artifact_density !== density_q[0]) begin
                $error("artifact_density expected %0d actual %0d", density_q[0],
                       o_artifact_density);
                fails++;
                void'(density_q.pop_front());
            end else begin
                void'(density_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/wse_pkg.sv
rtl/core/wse_front.sv
rtl/core/wse_queue.sv
rtl/core/wse_back.sv
rtl/core/windmill_streak_artifact_eval.sv
rtl/core/wse_check.sv
test/tb_windmill_streak_artifact_eval.sv
